@@ rtl/limap_pkg.sv @@
// Shared types, widths and register codes of the interpolated map block.
package limap_pkg;

   localparam int NUM_COMP = 4;
   localparam int COMP_W = 16;
   localparam int SAMPLE_W = 16;
   localparam int SCALE_W = 32;
   localparam int PROD_W = SAMPLE_W + SCALE_W;
   localparam int FRAC_W = 17;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_APPLY = 1'b1;

   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_INTERP = 1'b1;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_DOMAIN_MIN = 3'd1;
   localparam logic [2:0] REG_INDEX_SCALE = 3'd2;
   localparam logic [2:0] REG_MAP_LENGTH = 3'd3;
   localparam logic [2:0] REG_COMPONENTS = 3'd4;

   typedef logic [NUM_COMP-1:0][COMP_W-1:0] entry_type;

   typedef struct packed {
      logic                mode;
      logic [SAMPLE_W-1:0] domain_min;
      logic [SCALE_W-1:0]  index_scale;
      logic [2:0]          ncomp;
   } cfg_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
      logic en4;
      logic en5;
   } pipe_en_type;

endpackage

@@ rtl/limap_index.sv @@
// Front stages: input register, offset times slope, position clamp and index split.
module limap_index #(
   parameter int MAP_DEPTH = 256,
   localparam int IW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
   localparam int LEN_W = $clog2(MAP_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  limap_pkg::pipe_en_type        en,
   input  limap_pkg::cfg_type            cfg,
   input  logic [LEN_W-1:0]              len_eff,
   input  logic                          in_valid,
   input  logic                          in_kind,
   input  logic [limap_pkg::SAMPLE_W-1:0] in_sample,
   input  logic [7:0]                    in_index,
   input  limap_pkg::entry_type          in_entry,
   output logic                          v1,
   output logic                          v2,
   output logic                          v3,
   output logic                          s3_apply,
   output logic                          s3_wr_ok,
   output logic [IW-1:0]                 s3_widx,
   output limap_pkg::entry_type          s3_wdata,
   output logic [IW-1:0]                 s3_i0,
   output logic [IW-1:0]                 s3_i1,
   output logic [limap_pkg::FRAC_W-1:0]  s3_frac
);
   import limap_pkg::*;

   // stage 1: input register
   logic                v1_ff;
   logic                kind1_ff;
   logic [SAMPLE_W-1:0] sample1_ff;
   logic [7:0]          idx1_ff;
   entry_type           entry1_ff;

   // stage 2: position product
   logic                v2_ff;
   logic                kind2_ff;
   logic [PROD_W-1:0]   prod2_ff;
   logic                wr_ok2_ff;
   logic [IW-1:0]       widx2_ff;
   entry_type           entry2_ff;
   logic [SAMPLE_W-1:0] offset_in;
   logic [PROD_W-1:0]   prod_in;
   logic                wr_ok_in;

   // stage 3: table indexes and blend weight
   logic                v3_ff;
   logic                kind3_ff;
   logic                wr_ok3_ff;
   logic [IW-1:0]       widx3_ff;
   entry_type           entry3_ff;
   logic [IW-1:0]       i0_ff;
   logic [IW-1:0]       i1_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [IW-1:0]       i0_in;
   logic [IW-1:0]       i1_in;
   logic [FRAC_W-1:0]   frac_in;
   logic [31:0]         hi;
   logic [LEN_W-1:0]    last;
   logic                hi_ge_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en.en1) v1_ff <= in_valid;
         if (en.en2) v2_ff <= v1_ff;
         if (en.en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.en1) begin
         kind1_ff <= in_kind;
         sample1_ff <= in_sample;
         idx1_ff <= in_index;
         entry1_ff <= in_entry;
      end
   end

   // samples below the domain minimum land on position zero
   assign offset_in = (sample1_ff > cfg.domain_min) ? (sample1_ff - cfg.domain_min) : '0;
   assign prod_in = PROD_W'(offset_in) * PROD_W'(cfg.index_scale);
   assign wr_ok_in = {24'd0, idx1_ff} < MAP_DEPTH;

   always_ff @(posedge clock) begin
      if (en.en2) begin
         kind2_ff <= kind1_ff;
         prod2_ff <= prod_in;
         wr_ok2_ff <= wr_ok_in;
         widx2_ff <= IW'(idx1_ff);
         entry2_ff <= entry1_ff;
      end
   end

   // saturating at the table end only matters through the integer part
   assign hi = prod2_ff[PROD_W-1:16];
   assign last = len_eff - LEN_W'(1);
   assign hi_ge_last = hi >= 32'(last);

   always_comb begin
      i0_in = '0;
      i1_in = '0;
      frac_in = '0;
      if (cfg.mode == MODE_NEAREST) begin
         i0_in = hi_ge_last ? IW'(last) : hi[IW-1:0];
         i1_in = i0_in;
      end else if (len_eff == LEN_W'(1)) begin
         // single entry map: entry zero unblended
         i0_in = '0;
      end else if (hi_ge_last) begin
         // at or past the last entry: blend fully toward it
         i0_in = IW'(len_eff - LEN_W'(2));
         i1_in = IW'(last);
         frac_in = FRAC_ONE;
      end else begin
         i0_in = hi[IW-1:0];
         i1_in = hi[IW-1:0] + IW'(1);
         frac_in = {1'b0, prod2_ff[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en.en3) begin
         kind3_ff <= kind2_ff;
         wr_ok3_ff <= wr_ok2_ff;
         widx3_ff <= widx2_ff;
         entry3_ff <= entry2_ff;
         i0_ff <= i0_in;
         i1_ff <= i1_in;
         frac_ff <= frac_in;
      end
   end

   assign v1 = v1_ff;
   assign v2 = v2_ff;
   assign v3 = v3_ff;
   assign s3_apply = kind3_ff == KIND_APPLY;
   assign s3_wr_ok = wr_ok3_ff;
   assign s3_widx = widx3_ff;
   assign s3_wdata = entry3_ff;
   assign s3_i0 = i0_ff;
   assign s3_i1 = i1_ff;
   assign s3_frac = frac_ff;

endmodule

@@ rtl/limap_table.sv @@
// Map table stage: entry writes and two registered neighbor reads.
module limap_table #(
   parameter int MAP_DEPTH = 256,
   localparam int IW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  limap_pkg::pipe_en_type       en,
   input  logic                         v3,
   input  logic                         s3_apply,
   input  logic                         s3_wr_ok,
   input  logic [IW-1:0]                s3_widx,
   input  limap_pkg::entry_type         s3_wdata,
   input  logic [IW-1:0]                s3_i0,
   input  logic [IW-1:0]                s3_i1,
   input  logic [limap_pkg::FRAC_W-1:0] s3_frac,
   output logic                         v4,
   output limap_pkg::entry_type         rd_a,
   output limap_pkg::entry_type         rd_b,
   output logic [limap_pkg::FRAC_W-1:0] s4_frac
);
   import limap_pkg::*;

   entry_type         mem [MAP_DEPTH];
   logic              v4_ff;
   entry_type         rd_a_ff;
   entry_type         rd_b_ff;
   logic [FRAC_W-1:0] frac4_ff;

   // write items retire here and carry no valid further
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en.en4) begin
         v4_ff <= v3 && s3_apply;
      end
   end

   // writes and reads share this stage, so item order is kept
   always_ff @(posedge clock) begin
      if (en.en4 && v3 && !s3_apply && s3_wr_ok) begin
         mem[s3_widx] <= s3_wdata;
      end
      if (en.en4) begin
         rd_a_ff <= mem[s3_i0];
         rd_b_ff <= mem[s3_i1];
         frac4_ff <= s3_frac;
      end
   end

   assign v4 = v4_ff;
   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;
   assign s4_frac = frac4_ff;

endmodule

@@ rtl/limap_blend.sv @@
// Output stage: per-component linear blend into the result register.
module limap_blend (
   input  logic                         clock,
   input  logic                         reset,
   input  limap_pkg::pipe_en_type       en,
   input  logic [2:0]                   ncomp,
   input  logic                         v4,
   input  limap_pkg::entry_type         rd_a,
   input  limap_pkg::entry_type         rd_b,
   input  logic [limap_pkg::FRAC_W-1:0] s4_frac,
   output logic                         v5,
   output limap_pkg::entry_type         out_res
);
   import limap_pkg::*;

   logic                       v5_ff;
   entry_type                  res_ff;
   entry_type                  res_in;
   logic signed [COMP_W:0]     diff [NUM_COMP];
   logic signed [COMP_W+FRAC_W+1:0] mul [NUM_COMP];
   logic signed [COMP_W+FRAC_W+1:0] adj [NUM_COMP];

   // a + floor((b - a) * frac / 2^16) equals the truncated weighted sum
   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         diff[c] = $signed({1'b0, rd_b[c]}) - $signed({1'b0, rd_a[c]});
         mul[c] = (COMP_W+FRAC_W+2)'(diff[c]) * (COMP_W+FRAC_W+2)'($signed({1'b0, s4_frac}));
         adj[c] = mul[c] >>> 16;
         if (3'(c) < ncomp) begin
            res_in[c] = rd_a[c] + adj[c][COMP_W-1:0];
         end else begin
            res_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en.en5) begin
         v5_ff <= v4;
      end
   end

   always_ff @(posedge clock) begin
      if (en.en5) begin
         res_ff <= res_in;
      end
   end

   assign v5 = v5_ff;
   assign out_res = res_ff;

endmodule

@@ rtl/lut_and_interpolated_map_apply.sv @@
// Top level: register file, stall chain and the five-stage map pipeline.
//
// Maps samples through a 1D table of up to four 16-bit components per entry.
// A write item (kind 0) loads one table entry and gives no result; an apply
// item (kind 1) gives exactly one result. One item is accepted every cycle
// unless the input stalls: stages are input register, offset times slope,
// position clamp and index split, table read (two neighbor entries at once,
// writes in the same stage so item order holds), and the per-component
// blend. A stage with no item never holds back the stages behind it, so
// input stalls only when all five stages are full and the result is stalled.
// Table contents are undefined until written. The user must write registers
// through the APB port only while no item is in flight; nothing enforces it.
module lut_and_interpolated_map_apply #(
   parameter int MAP_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [15:0]                    req_sample,
   input  logic [7:0]                     req_entry_index,
   input  logic [15:0]                    req_entry_c0,
   input  logic [15:0]                    req_entry_c1,
   input  logic [15:0]                    req_entry_c2,
   input  logic [15:0]                    req_entry_c3,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [15:0]                    rsp_out_c0,
   output logic [15:0]                    rsp_out_c1,
   output logic [15:0]                    rsp_out_c2,
   output logic [15:0]                    rsp_out_c3,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [limap_pkg::ADDR_W-1:0]   paddr,
   input  logic [limap_pkg::DATA_W-1:0]   pwdata,
   output logic [limap_pkg::DATA_W-1:0]   prdata,
   output logic                           pready
);
   import limap_pkg::*;

   localparam int IW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int LEN_W = $clog2(MAP_DEPTH + 1);
   localparam int CMP_W = (LEN_W > 9) ? LEN_W : 9;

   logic        mode_ff;
   logic [15:0] domain_min_ff;
   logic [31:0] index_scale_ff;
   logic [8:0]  map_length_ff;
   logic [2:0]  components_ff;
   logic        csr_wr;

   logic [CMP_W-1:0] len_raw;
   logic [LEN_W-1:0] len_eff;
   logic [2:0]       ncomp_eff;
   cfg_type          cfg;
   pipe_en_type      en;

   logic              v1, v2, v3, v4, v5;
   logic              s3_apply;
   logic              s3_wr_ok;
   logic [IW-1:0]     s3_widx;
   entry_type         s3_wdata;
   logic [IW-1:0]     s3_i0;
   logic [IW-1:0]     s3_i1;
   logic [FRAC_W-1:0] s3_frac;
   entry_type         rd_a;
   entry_type         rd_b;
   logic [FRAC_W-1:0] s4_frac;
   entry_type         in_entry;
   entry_type         out_res;

   // register file
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_INTERP;
         domain_min_ff <= '0;
         index_scale_ff <= 32'd65536;
         map_length_ff <= 9'd256;
         components_ff <= 3'd4;
      end else if (csr_wr) begin
         unique case (paddr[4:2])
            REG_MODE:        mode_ff <= pwdata[0];
            REG_DOMAIN_MIN:  domain_min_ff <= pwdata[15:0];
            REG_INDEX_SCALE: index_scale_ff <= pwdata;
            REG_MAP_LENGTH:  map_length_ff <= pwdata[8:0];
            REG_COMPONENTS:  components_ff <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_MODE:        prdata = {31'd0, mode_ff};
         REG_DOMAIN_MIN:  prdata = {16'd0, domain_min_ff};
         REG_INDEX_SCALE: prdata = index_scale_ff;
         REG_MAP_LENGTH:  prdata = {23'd0, map_length_ff};
         REG_COMPONENTS:  prdata = {29'd0, components_ff};
         default:         prdata = '0;
      endcase
   end

   // clamp length and component count to what the table holds
   assign len_raw = CMP_W'(map_length_ff);

   always_comb begin
      if (len_raw == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_raw > CMP_W'(MAP_DEPTH)) begin
         len_eff = LEN_W'(MAP_DEPTH);
      end else begin
         len_eff = LEN_W'(len_raw);
      end
      if (components_ff == 3'd0) begin
         ncomp_eff = 3'd1;
      end else if (components_ff > 3'(NUM_COMP)) begin
         ncomp_eff = 3'(NUM_COMP);
      end else begin
         ncomp_eff = components_ff;
      end
   end

   assign cfg.mode = mode_ff;
   assign cfg.domain_min = domain_min_ff;
   assign cfg.index_scale = index_scale_ff;
   assign cfg.ncomp = ncomp_eff;

   // advance a stage when it is empty or the stage after it advances
   assign en.en5 = !v5 || !rsp_stall;
   assign en.en4 = !v4 || en.en5;
   assign en.en3 = !v3 || en.en4;
   assign en.en2 = !v2 || en.en3;
   assign en.en1 = !v1 || en.en2;
   assign req_stall = !en.en1;

   assign in_entry[0] = req_entry_c0;
   assign in_entry[1] = req_entry_c1;
   assign in_entry[2] = req_entry_c2;
   assign in_entry[3] = req_entry_c3;

   limap_index #(
      .MAP_DEPTH(MAP_DEPTH)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .len_eff   (len_eff),
      .in_valid  (req_valid),
      .in_kind   (req_kind),
      .in_sample (req_sample),
      .in_index  (req_entry_index),
      .in_entry  (in_entry),
      .v1        (v1),
      .v2        (v2),
      .v3        (v3),
      .s3_apply  (s3_apply),
      .s3_wr_ok  (s3_wr_ok),
      .s3_widx   (s3_widx),
      .s3_wdata  (s3_wdata),
      .s3_i0     (s3_i0),
      .s3_i1     (s3_i1),
      .s3_frac   (s3_frac)
   );

   limap_table #(
      .MAP_DEPTH(MAP_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .v3       (v3),
      .s3_apply (s3_apply),
      .s3_wr_ok (s3_wr_ok),
      .s3_widx  (s3_widx),
      .s3_wdata (s3_wdata),
      .s3_i0    (s3_i0),
      .s3_i1    (s3_i1),
      .s3_frac  (s3_frac),
      .v4       (v4),
      .rd_a     (rd_a),
      .rd_b     (rd_b),
      .s4_frac  (s4_frac)
   );

   limap_blend u_blend (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ncomp   (ncomp_eff),
      .v4      (v4),
      .rd_a    (rd_a),
      .rd_b    (rd_b),
      .s4_frac (s4_frac),
      .v5      (v5),
      .out_res (out_res)
   );

   assign rsp_valid = v5;
   assign rsp_out_c0 = out_res[0];
   assign rsp_out_c1 = out_res[1];
   assign rsp_out_c2 = out_res[2];
   assign rsp_out_c3 = out_res[3];

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1 && v2 && v3 && v4 && rsp_valid && rsp_stall))
      else $error("input stalled while the pipeline has an empty stage");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (v3 && s3_apply) |-> ((LEN_W+1)'(s3_i1) < (LEN_W+1)'(len_eff) && s3_i0 <= s3_i1))
      else $error("table index outside the entries in use");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ncomp_eff == 3'd1) |->
         (rsp_out_c1 == '0 && rsp_out_c2 == '0 && rsp_out_c3 == '0))
      else $error("unused component of a result is not zero");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the interpolated map block: directed table, then random phases.
module tb_top;
   import limap_pkg::*;

   localparam int MAP_DEPTH = 256;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 115;

   typedef struct {
      bit          is_cfg;
      logic [2:0]  reg_code;
      logic [31:0] value;
      logic        kind;
      logic [15:0] sample;
      logic [7:0]  idx;
      entry_type   comps;
      bit          typed;
      entry_type   want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_WRITE;
   logic [15:0] req_sample = '0;
   logic [7:0]  req_entry_index = '0;
   logic [15:0] req_entry_c0 = '0;
   logic [15:0] req_entry_c1 = '0;
   logic [15:0] req_entry_c2 = '0;
   logic [15:0] req_entry_c3 = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_out_c0;
   logic [15:0] rsp_out_c1;
   logic [15:0] rsp_out_c2;
   logic [15:0] rsp_out_c3;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic        pready;

   // predictor copy of the block's registers and table
   logic        cfg_mode = MODE_INTERP;
   logic [15:0] cfg_dmin = 16'd0;
   logic [31:0] cfg_scale = 32'd65536;
   logic [8:0]  cfg_len = 9'd256;
   logic [2:0]  cfg_ncomp = 3'd4;
   entry_type   map_mem [MAP_DEPTH];

   entry_type    map_expect_q [$];
   plan_row_type dir_plan [$];
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;

   lut_and_interpolated_map_apply #(.MAP_DEPTH(MAP_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_sample(req_sample), .req_entry_index(req_entry_index),
      .req_entry_c0(req_entry_c0), .req_entry_c1(req_entry_c1),
      .req_entry_c2(req_entry_c2), .req_entry_c3(req_entry_c3),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_c0(rsp_out_c0), .rsp_out_c1(rsp_out_c1),
      .rsp_out_c2(rsp_out_c2), .rsp_out_c3(rsp_out_c3),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic entry_type ent(logic [15:0] c0, logic [15:0] c1,
                                     logic [15:0] c2, logic [15:0] c3);
      return {c3, c2, c1, c0};
   endfunction

   function automatic longint unsigned eff_length();
      if (cfg_len == 0) return 1;
      if (cfg_len > MAP_DEPTH) return MAP_DEPTH;
      return cfg_len;
   endfunction

   function automatic entry_type map_predict(logic [15:0] smp);
      longint unsigned len, ofs, cap, pos, last, i0, i1, frac, a, b;
      int unsigned nc;
      entry_type r;
      len = eff_length();
      nc = (cfg_ncomp == 0) ? 1 : ((cfg_ncomp > 4) ? 4 : cfg_ncomp);
      ofs = (smp > cfg_dmin) ? smp - cfg_dmin : 0;
      cap = len << 16;
      pos = ofs * cfg_scale;
      if (pos > cap) pos = cap;
      if (cfg_mode == MODE_NEAREST) begin
         i0 = pos >> 16;
         if (i0 > len - 1) i0 = len - 1;
         i1 = i0;
         frac = 0;
      end else if (len == 1) begin
         i0 = 0;
         i1 = 0;
         frac = 0;
      end else begin
         last = (len - 1) << 16;
         if (pos > last) pos = last;
         i0 = pos >> 16;
         // step back so the upper neighbor stays inside the table
         if (i0 == len - 1) i0 = i0 - 1;
         i1 = i0 + 1;
         frac = pos - (i0 << 16);
      end
      r = '0;
      for (int c = 0; c < nc; c++) begin
         a = map_mem[i0][c];
         b = map_mem[i1][c];
         r[c] = 16'((a * (65536 - frac) + b * frac) >> 16);
      end
      return r;
   endfunction

   function automatic int idle_run();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_wr(logic [7:0] idx, entry_type comps);
      plan_row_type row;
      row = '{default: '0};
      row.kind = KIND_WRITE;
      row.idx = idx;
      row.comps = comps;
      dir_plan.push_back(row);
   endfunction

   function automatic void add_ap(logic [15:0] smp, bit typed, entry_type want);
      plan_row_type row;
      row = '{default: '0};
      row.kind = KIND_APPLY;
      row.sample = smp;
      row.typed = typed;
      row.want = want;
      dir_plan.push_back(row);
   endfunction

   function automatic void add_cfg(logic [2:0] code, logic [31:0] value);
      plan_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.reg_code = code;
      row.value = value;
      dir_plan.push_back(row);
   endfunction

   task automatic send_item(logic kind, logic [15:0] smp, logic [7:0] idx,
                            entry_type comps, bit typed, entry_type want);
      int gap;
      gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_run();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_sample <= smp;
      req_entry_index <= idx;
      req_entry_c0 <= comps[0];
      req_entry_c1 <= comps[1];
      req_entry_c2 <= comps[2];
      req_entry_c3 <= comps[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_WRITE) map_mem[idx] = comps;
      else map_expect_q.push_back(typed ? want : map_predict(smp));
   endtask

   // drop valid, drain the pipeline and let trailing writes settle
   task automatic settle();
      req_valid <= 1'b0;
      while (map_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] code, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {code, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (code)
         REG_MODE:        cfg_mode = value[0];
         REG_DOMAIN_MIN:  cfg_dmin = value[15:0];
         REG_INDEX_SCALE: cfg_scale = value;
         REG_MAP_LENGTH:  cfg_len = value[8:0];
         REG_COMPONENTS:  cfg_ncomp = value[2:0];
         default: ;
      endcase
   endtask

   // result side: random stall bursts, off in calm phases
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_stall <= 1'b1;
         stall_left = idle_run() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      entry_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_c3, rsp_out_c2, rsp_out_c1, rsp_out_c0};
         if (map_expect_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
         end else begin
            want = map_expect_q.pop_front();
            for (int c = 0; c < 4; c++) begin
               if (got[c] !== want[c]) begin
                  mismatch_count++;
                  $display("%0t: out_c%0d expected %h, got %h", $time, c, want[c], got[c]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      longint unsigned span, s;
      logic [31:0] v;
      entry_type comps;

      add_wr(8'd0,   ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
      add_wr(8'd1,   ent(16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555));
      add_wr(8'd2,   ent(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE));
      add_wr(8'd254, ent(16'h0001, 16'h0002, 16'h0003, 16'h0004));
      add_wr(8'd255, ent(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_ap(16'h0000, 1, ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
      add_ap(16'hFFFF, 1, ent(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_ap(16'h0001, 0, '0);
      add_cfg(REG_MODE, MODE_NEAREST);
      add_ap(16'h0002, 0, '0);
      add_ap(16'hFFFF, 1, ent(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_cfg(REG_MODE, MODE_INTERP);
      add_cfg(REG_INDEX_SCALE, 32'h0000_8000);
      add_ap(16'h0001, 0, '0);
      add_ap(16'h0003, 0, '0);
      // component count of zero keeps only out_c0
      add_cfg(REG_COMPONENTS, 32'd0);
      add_ap(16'h0000, 1, ent(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      add_cfg(REG_COMPONENTS, 32'd7);
      add_ap(16'h0003, 0, '0);
      // single entry map, then a length of zero that acts as one
      add_cfg(REG_MAP_LENGTH, 32'd1);
      add_ap(16'hFFFF, 1, ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
      add_cfg(REG_MODE, MODE_NEAREST);
      add_ap(16'h1234, 1, ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
      add_cfg(REG_MAP_LENGTH, 32'd0);
      add_cfg(REG_MODE, MODE_INTERP);
      add_ap(16'h0FFF, 1, ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
      // oversized length, saturating position
      add_cfg(REG_MAP_LENGTH, 32'd511);
      add_cfg(REG_INDEX_SCALE, 32'hFFFF_FFFF);
      add_ap(16'h0001, 1, ent(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_ap(16'h0000, 1, ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
      add_wr(8'd255, ent(16'h1111, 16'h2222, 16'h3333, 16'h4444));
      add_ap(16'h0001, 1, ent(16'h1111, 16'h2222, 16'h3333, 16'h4444));
      // samples at and below the domain minimum map to position zero
      add_cfg(REG_DOMAIN_MIN, 32'h0000_FFFF);
      add_ap(16'hFFFF, 1, ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
      add_ap(16'h8000, 1, ent(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_plan[i]) begin
         if (dir_plan[i].is_cfg) begin
            settle();
            write_csr(dir_plan[i].reg_code, dir_plan[i].value);
         end else begin
            send_item(dir_plan[i].kind, dir_plan[i].sample, dir_plan[i].idx,
                      dir_plan[i].comps, dir_plan[i].typed, dir_plan[i].want);
         end
      end

      // load every entry so no later read can touch an unwritten one
      for (int i = 0; i < MAP_DEPTH; i++)
         send_item(KIND_WRITE, 16'($urandom), 8'(i), {$urandom, $urandom}, 0, '0);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         calm = (ph % 4 == 3);
         write_csr(REG_MODE, $urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: v = 32'd0;
            1: v = 32'h0000_FFFF;
            2: v = $urandom_range(0, 255);
            default: v = $urandom_range(0, 65535);
         endcase
         write_csr(REG_DOMAIN_MIN, v);
         case ($urandom_range(0, 8))
            0: v = 32'd0;
            1: v = 32'd1;
            2: v = 32'd2;
            3: v = 32'd256;
            4: v = $urandom_range(257, 511);
            5: v = 32'd511;
            default: v = $urandom_range(1, 256);
         endcase
         write_csr(REG_MAP_LENGTH, v);
         write_csr(REG_COMPONENTS, $urandom_range(0, 7));
         case ($urandom_range(0, 7))
            0: v = 32'd0;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h0001_0000;
            3: v = $urandom;
            default: begin
               // fit the table onto a random sample span
               span = $urandom_range(16, 65535);
               v = 32'(((eff_length() << 16) / span) + $urandom_range(0, 1));
            end
         endcase
         write_csr(REG_INDEX_SCALE, v);

         if (cfg_scale == 0) span = 65535;
         else span = ((eff_length() << 16) / cfg_scale) + 1;
         if (span > 65535) span = 65535;

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 20) begin
               case ($urandom_range(0, 9))
                  0: comps = '0;
                  1: comps = '1;
                  default: comps = {$urandom, $urandom};
               endcase
               send_item(KIND_WRITE, 16'($urandom), 8'($urandom), comps, 0, '0);
            end else begin
               if ($urandom_range(0, 99) < 75) begin
                  s = cfg_dmin + $urandom_range(0, 32'(span));
                  if (s > 65535) s = 65535;
               end else begin
                  s = $urandom_range(0, 65535);
               end
               send_item(KIND_APPLY, 16'(s), 8'($urandom), {$urandom, $urandom}, 0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (map_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && map_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/limap_pkg.sv
rtl/limap_index.sv
rtl/limap_table.sv
rtl/limap_blend.sv
rtl/lut_and_interpolated_map_apply.sv
bench/tb_top.sv
